[design/gcd_pkg.sv]
// shared types, constants and character decode for the gamepad chord decoder
`default_nettype none

package gcd_pkg;

   localparam int BUTTON_COUNT = 8;

   localparam int NOW_WIDTH    = 32;
   localparam int HOLD_WIDTH   = 16;
   localparam int STEP_WIDTH   = 8;
   localparam int DELTA_WIDTH  = 9;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   typedef logic [BUTTON_COUNT-1:0] button_mask_type;
   typedef logic [NOW_WIDTH-1:0]    time_ms_type;

   // button bit positions
   localparam int BIT_A      = 0;
   localparam int BIT_B      = 1;
   localparam int BIT_SELECT = 2;
   localparam int BIT_START  = 3;
   localparam int BIT_UP     = 4;
   localparam int BIT_DOWN   = 5;
   localparam int BIT_LEFT   = 6;
   localparam int BIT_RIGHT  = 7;

   localparam button_mask_type KEY_NONE   = 8'h00;
   localparam button_mask_type KEY_A      = 8'h01;
   localparam button_mask_type KEY_B      = 8'h02;
   localparam button_mask_type KEY_SELECT = 8'h04;
   localparam button_mask_type KEY_START  = 8'h08;
   localparam button_mask_type KEY_UP     = 8'h10;
   localparam button_mask_type KEY_DOWN   = 8'h20;
   localparam button_mask_type KEY_LEFT   = 8'h40;
   localparam button_mask_type KEY_RIGHT  = 8'h80;

   typedef enum logic {
      FUNC_CHAR = 1'b0,
      FUNC_POLL = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_SERIAL_ENABLE  = 3'd0,
      CSR_ONBOARD_ENABLE = 3'd1,
      CSR_SERIAL_HOLD_MS = 3'd2,
      CSR_QUIT_HOLD_MS   = 3'd3,
      CSR_BRIGHT_STEP    = 3'd4
   } csr_index_type;

   localparam logic                  RESET_SERIAL_ENABLE  = 1'b1;
   localparam logic                  RESET_ONBOARD_ENABLE = 1'b1;
   localparam logic [HOLD_WIDTH-1:0] RESET_SERIAL_HOLD_MS = 16'd90;
   localparam logic [HOLD_WIDTH-1:0] RESET_QUIT_HOLD_MS   = 16'd750;
   localparam logic [STEP_WIDTH-1:0] RESET_BRIGHT_STEP    = 8'd8;

   // console key codes
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UD    = 8'h44;
   localparam logic [7:0] CH_UJ    = 8'h4A;
   localparam logic [7:0] CH_UK    = 8'h4B;
   localparam logic [7:0] CH_US    = 8'h53;
   localparam logic [7:0] CH_UW    = 8'h57;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LD    = 8'h64;
   localparam logic [7:0] CH_LJ    = 8'h6A;
   localparam logic [7:0] CH_LK    = 8'h6B;
   localparam logic [7:0] CH_LS    = 8'h73;
   localparam logic [7:0] CH_LW    = 8'h77;

   function automatic button_mask_type char_to_button(input logic [7:0] ch);
      button_mask_type mask;
      case (ch) inside
         CH_LW, CH_UW:    mask = KEY_UP;
         CH_LS, CH_US:    mask = KEY_DOWN;
         CH_LA, CH_UA:    mask = KEY_LEFT;
         CH_LD, CH_UD:    mask = KEY_RIGHT;
         CH_LK, CH_UK:    mask = KEY_A;
         CH_LJ, CH_UJ:    mask = KEY_B;
         CH_CR, CH_LF:    mask = KEY_START;
         CH_SPACE:        mask = KEY_SELECT;
         default:         mask = KEY_NONE;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

[design/gamepad_chord_decoder_unit.sv]
// gamepad chord decoder top level: source merge, console hold timers, chord events
`default_nettype none

// Accepts one transaction per clock while req_stall is low. A transaction is
// registered at the input and, when it leaves the input register, decoded
// by a single layer of logic (eight parallel 32-bit deadline compares, one
// 32-bit elapsed-time compare and the chord edge detectors); a poll's result
// is written to the response register. A console character transaction only
// updates the hold deadline of its button, if serial input is enabled, and
// produces no response. Input and response registers are separate, so a new
// transaction is taken while a response waits; req_stall rises only when a
// poll waits in the input register while the response register is full and
// rsp_stall is high. Configuration is written through csr_* while no
// transaction is in flight; the user must ensure it, the block does not.
module gamepad_chord_decoder_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_func,
   input  wire  [gcd_pkg::NOW_WIDTH-1:0]    req_now_ms,
   input  wire  [7:0]                       req_serial_char,
   input  wire  [gcd_pkg::BUTTON_COUNT-1:0] req_pin_levels,
   input  wire  [1:0]                       req_onboard_levels,
   input  wire  [gcd_pkg::BUTTON_COUNT-1:0] req_remote_buttons,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [gcd_pkg::BUTTON_COUNT-1:0] rsp_pad_state,
   output logic                             rsp_quit_request,
   output logic                             rsp_invert_toggle,
   output logic                             rsp_mode_advance,
   output logic signed [gcd_pkg::DELTA_WIDTH-1:0] rsp_bright_delta,
   input  wire                              csr_write_enable,
   input  wire  [gcd_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire  [gcd_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import gcd_pkg::*;

   // configuration
   logic                  serial_enable_ff;
   logic                  onboard_enable_ff;
   logic [HOLD_WIDTH-1:0] serial_hold_ff;
   logic [HOLD_WIDTH-1:0] quit_hold_ff;
   logic [STEP_WIDTH-1:0] bright_step_ff;

   // input register
   logic            s1_valid_ff;
   func_type        s1_func_ff;
   time_ms_type     s1_now_ff;
   logic [7:0]      s1_char_ff;
   button_mask_type s1_pins_ff;
   logic [1:0]      s1_onboard_ff;
   button_mask_type s1_remote_ff;

   // decoder state
   time_ms_type     deadline_ff [BUTTON_COUNT];
   logic            quit_timing_ff;
   time_ms_type     quit_start_ff;
   logic            invert_prev_ff;
   logic            mode_prev_ff;
   logic            bright_prev_ff;

   // response register
   logic                          out_valid_ff;
   button_mask_type               out_pad_ff;
   logic                          out_quit_ff;
   logic                          out_invert_ff;
   logic                          out_mode_ff;
   logic signed [DELTA_WIDTH-1:0] out_delta_ff;

   logic            s1_advance;
   logic            accept;
   logic            do_char;
   logic            do_poll;

   button_mask_type console_mask;
   button_mask_type char_mask;
   time_ms_type     hold_target;
   button_mask_type merged;
   button_mask_type pad_a;
   button_mask_type pad_b;
   button_mask_type pad_c;
   button_mask_type pad_in;
   logic            quit_chord;
   time_ms_type     start_eff;
   time_ms_type     elapsed;
   logic            quit_in;
   logic            quit_timing_in;
   time_ms_type     quit_start_in;
   logic            sel;
   logic            invert_chord;
   logic            mode_chord;
   logic            bright_chord;
   logic            invert_in;
   logic            mode_in;
   logic signed [DELTA_WIDTH-1:0] delta_in;
   time_ms_type     diff [BUTTON_COUNT];

   assign s1_advance = s1_valid_ff
                       && (s1_func_ff == FUNC_CHAR || !out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign accept     = req_valid && !req_stall;
   assign do_char    = s1_advance && s1_func_ff == FUNC_CHAR;
   assign do_poll    = s1_advance && s1_func_ff == FUNC_POLL;

   assign char_mask   = char_to_button(s1_char_ff);
   assign hold_target = s1_now_ff + {{(NOW_WIDTH-HOLD_WIDTH){1'b0}}, serial_hold_ff};

   always_comb begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         diff[i] = deadline_ff[i] - s1_now_ff;
         console_mask[i] = (diff[i] != '0) && !diff[i][NOW_WIDTH-1];
      end
   end

   always_comb begin
      merged = ~s1_pins_ff | s1_remote_ff;
      if (onboard_enable_ff) begin
         merged[BIT_A]     = merged[BIT_A] | !s1_onboard_ff[0];
         merged[BIT_START] = merged[BIT_START] | !s1_onboard_ff[1];
      end
      if (serial_enable_ff) begin
         merged = merged | console_mask;
      end
   end

   // quit chord
   assign quit_chord    = merged[BIT_SELECT] && merged[BIT_START];
   assign start_eff     = quit_timing_ff ? quit_start_ff : s1_now_ff;
   assign elapsed       = s1_now_ff - start_eff;
   assign quit_in       = quit_chord
                          && (elapsed >= {{(NOW_WIDTH-HOLD_WIDTH){1'b0}}, quit_hold_ff});
   assign quit_timing_in = quit_chord && !quit_in;
   assign quit_start_in  = start_eff;
   assign pad_a = quit_chord ? (merged & ~(KEY_SELECT | KEY_START)) : merged;

   // select chords, select sampled once after quit
   assign sel          = pad_a[BIT_SELECT];
   assign invert_chord = sel && pad_a[BIT_B];
   assign invert_in    = invert_chord && !invert_prev_ff;
   assign pad_b        = invert_chord ? (pad_a & ~(KEY_SELECT | KEY_B)) : pad_a;

   assign mode_chord   = sel && pad_b[BIT_A];
   assign mode_in      = mode_chord && !mode_prev_ff;
   assign pad_c        = mode_chord ? (pad_b & ~(KEY_SELECT | KEY_A)) : pad_b;

   assign bright_chord = sel && (pad_c[BIT_UP] || pad_c[BIT_DOWN]);
   assign pad_in       = bright_chord ? (pad_c & ~(KEY_SELECT | KEY_UP | KEY_DOWN)) : pad_c;

   always_comb begin
      delta_in = '0;
      if (bright_chord && !bright_prev_ff) begin
         if (pad_c[BIT_UP]) begin
            delta_in = $signed({1'b0, bright_step_ff});
         end else begin
            delta_in = -$signed({1'b0, bright_step_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_enable_ff  <= RESET_SERIAL_ENABLE;
         onboard_enable_ff <= RESET_ONBOARD_ENABLE;
         serial_hold_ff    <= RESET_SERIAL_HOLD_MS;
         quit_hold_ff      <= RESET_QUIT_HOLD_MS;
         bright_step_ff    <= RESET_BRIGHT_STEP;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SERIAL_ENABLE:  serial_enable_ff  <= csr_write_data[0];
            CSR_ONBOARD_ENABLE: onboard_enable_ff <= csr_write_data[0];
            CSR_SERIAL_HOLD_MS: serial_hold_ff    <= csr_write_data[HOLD_WIDTH-1:0];
            CSR_QUIT_HOLD_MS:   quit_hold_ff      <= csr_write_data[HOLD_WIDTH-1:0];
            CSR_BRIGHT_STEP:    bright_step_ff    <= csr_write_data[STEP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff    <= func_type'(req_func);
         s1_now_ff     <= req_now_ms;
         s1_char_ff    <= req_serial_char;
         s1_pins_ff    <= req_pin_levels;
         s1_onboard_ff <= req_onboard_levels;
         s1_remote_ff  <= req_remote_buttons;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            deadline_ff[i] <= '0;
         end
      end else if (do_char && serial_enable_ff) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (char_mask[i]) begin
               deadline_ff[i] <= hold_target;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quit_timing_ff <= 1'b0;
         quit_start_ff  <= '0;
         invert_prev_ff <= 1'b0;
         mode_prev_ff   <= 1'b0;
         bright_prev_ff <= 1'b0;
      end else if (do_poll) begin
         quit_timing_ff <= quit_timing_in;
         if (quit_chord) begin
            quit_start_ff <= quit_start_in;
         end
         invert_prev_ff <= invert_chord;
         mode_prev_ff   <= mode_chord;
         bright_prev_ff <= bright_chord;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (do_poll) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_poll) begin
         out_pad_ff    <= pad_in;
         out_quit_ff   <= quit_in;
         out_invert_ff <= invert_in;
         out_mode_ff   <= mode_in;
         out_delta_ff  <= delta_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pad_state     = out_pad_ff;
   assign rsp_quit_request  = out_quit_ff;
   assign rsp_invert_toggle = out_invert_ff;
   assign rsp_mode_advance  = out_mode_ff;
   assign rsp_bright_delta  = out_delta_ff;

endmodule

`default_nettype wire

[design/gcd_checker.sv]
// port-level checker for the gamepad chord decoder and its bind
`default_nettype none

module gcd_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire [gcd_pkg::BUTTON_COUNT-1:0]  rsp_pad_state,
   input wire                              rsp_quit_request,
   input wire                              rsp_invert_toggle,
   input wire                              rsp_mode_advance,
   input wire [gcd_pkg::DELTA_WIDTH-1:0]   rsp_bright_delta
);
   import gcd_pkg::*;

   // stalled response stays valid and holds its pad state, quit request and brightness delta
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pad_state)
         && $stable(rsp_bright_delta) && $stable(rsp_quit_request))
      else $error("stalled response transaction changed");

   // a fired chord removes its buttons from the pad mask
   quit_clear_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_quit_request |->
         !rsp_pad_state[BIT_SELECT] && !rsp_pad_state[BIT_START])
      else $error("quit with select or start still in pad mask");

   invert_clear_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invert_toggle |->
         !rsp_pad_state[BIT_SELECT] && !rsp_pad_state[BIT_B])
      else $error("invert with select or b still in pad mask");

   mode_clear_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_advance || rsp_bright_delta != '0) |->
         !rsp_pad_state[BIT_SELECT] && !rsp_pad_state[BIT_A] == rsp_mode_advance
         || !rsp_pad_state[BIT_SELECT] && !rsp_pad_state[BIT_UP] && !rsp_pad_state[BIT_DOWN])
      else $error("mode or brightness event with chord buttons in pad mask");

   // no response right after reset
   reset_idle_a: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind gamepad_chord_decoder_unit gcd_checker u_gcd_checker (.*);

`default_nettype wire
